/* hdl/f2i_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_pkg: shared types, constants and rounding function of the fp32 / int64 conversion unit
// ----------------------------------------------------------------------------
package f2i_pkg;

  typedef enum logic [1:0] {
    REQ_F2S = 2'd0,
    REQ_F2U = 2'd1,
    REQ_S2F = 2'd2,
    REQ_U2F = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RTZ = 3'd1,
    RM_RDN = 3'd2,
    RM_RUP = 3'd3,
    RM_RMM = 3'd4,
    RM_DYN = 3'd7
  } rm_e;

  localparam logic [4:0]  FLAG_NV  = 5'h10;
  localparam logic [4:0]  FLAG_NX  = 5'h01;
  localparam logic [31:0] BOX_HIGH = 32'hFFFF_FFFF;

  // Round-up decision from lsb, guard (half) bit and sticky (rest) bit.
  function automatic logic round_up(input logic [2:0] mode, input logic neg,
                                    input logic lsb, input logic grd,
                                    input logic stk);
    logic inx;
    inx = grd | stk;
    case (mode)
      RM_RNE:  round_up = grd & (stk | lsb);
      RM_RDN:  round_up = inx & neg;
      RM_RUP:  round_up = inx & ~neg;
      RM_RMM:  round_up = grd;
      default: round_up = 1'b0;
    endcase
  endfunction

endpackage

/* hdl/fp32_int64_conversion_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_int64_conversion_unit: RV64F FCVT between binary32 and 64-bit integers
// Four-stage pipeline: decode/align, shift, round, saturate/pack.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid_i/in_stall_o   | req_type_i, operand_bits_i, rounding_field_i
// out      | out_valid_o/out_stall_i | result_bits_o, exception_flags_o,
//          |                         | illegal_rounding_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i (dynamic rounding mode)
// One request per cycle while in_stall_o is low.
// Reset clears all valid bits and the dynamic mode (RNE).
// A stall at the output holds every full stage back to the first bubble; bubbles
// are squeezed out since a stage advances whenever the next one is empty or moving.
module fp32_int64_conversion_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] operand_bits_i,
  input  logic [2:0]  rounding_field_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_bits_o,
  output logic [4:0]  exception_flags_o,
  output logic        illegal_rounding_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);
  import f2i_pkg::*;

  logic [2:0] dyn_rm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_rm_q <= RM_RNE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dyn_rm_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: decode, magnitude, shift amount ----------------
  // Float to int: mantissa (24b) goes into a 64+32 bit frame; shift left by
  // e+32 where e = exp-150, clipped. Int to float: shift left by leading zeros.
  logic [2:0]  mode;
  logic        illegal_d;
  logic        f2i;
  logic        neg_d;
  logic [63:0] mag_d;
  logic [6:0]  sh_d;       // left shift amount
  logic        spec_d;     // NaN/inf/overflow special
  logic [63:0] spec_res_d;
  logic        zero_d;
  logic [7:0]  exp;
  logic [23:0] man;
  logic        is_uns;
  logic [5:0]  lz;
  logic        found;

  always_comb begin
    mode      = (rounding_field_i == RM_DYN) ? dyn_rm_q : rounding_field_i;
    illegal_d = (mode == 3'd5) || (mode == 3'd6) || (mode == 3'd7);
    f2i       = (req_type_i == REQ_F2S) || (req_type_i == REQ_F2U);
    is_uns    = (req_type_i == REQ_F2U);
    exp       = operand_bits_i[30:23];
    man       = {exp != 8'd0, operand_bits_i[22:0]};
    spec_d    = 1'b0;
    spec_res_d = '0;
    zero_d    = 1'b0;
    lz        = '0;
    found     = 1'b0;
    if (f2i) begin
      neg_d = operand_bits_i[31];
      mag_d = {40'd0, man};
      // e = max(exp,1)-150; left shift into [95:0] frame by e+32, rs<=30 clip
      if (exp == 8'hFF) begin
        spec_d = 1'b1;
        spec_res_d = (operand_bits_i[22:0] != 23'd0 || !neg_d) ?
                     (is_uns ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF) :
                     (is_uns ? 64'd0 : 64'h8000_0000_0000_0000);
        sh_d = '0;
      end else if (exp > 8'd190) begin
        spec_d = 1'b1;
        spec_res_d = neg_d ? (is_uns ? 64'd0 : 64'h8000_0000_0000_0000) :
                     (is_uns ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF);
        sh_d = '0;
      end else if (exp < 8'd121) begin
        sh_d = 7'd2;   // rs clipped at 30 -> e+32 = 2
        if (exp == 8'd0) sh_d = 7'd2;
      end else begin
        sh_d = 7'(exp - 8'd118);  // exp-150+32
      end
    end else begin
      neg_d = (req_type_i == REQ_S2F) && operand_bits_i[63];
      mag_d = neg_d ? (64'd0 - operand_bits_i) : operand_bits_i;
      zero_d = (mag_d == 64'd0);
      for (int i = 63; i >= 0; i--) begin
        if (!found && mag_d[i]) begin
          found = 1'b1;
          lz = 6'(63 - i);
        end
      end
      sh_d = {1'b0, lz};
    end
  end

  logic        f2i_q1, uns_q1, neg_q1, ill_q1, spec_q1, zero_q1;
  logic [2:0]  mode_q1;
  logic [63:0] mag_q1, specr_q1;
  logic [6:0]  sh_q1;
  always_ff @(posedge clk_i) begin
    if (en1) begin
      f2i_q1 <= f2i; uns_q1 <= is_uns || (req_type_i == REQ_U2F);
      neg_q1 <= neg_d; ill_q1 <= illegal_d; spec_q1 <= spec_d;
      zero_q1 <= zero_d; mode_q1 <= mode; mag_q1 <= mag_d;
      specr_q1 <= spec_res_d; sh_q1 <= sh_d;
    end
  end

  // ---------------- stage 2: shift ----------------
  // f2i: frame[95:0] = mag << sh; integer part [95:32], fraction [31:0].
  // i2f: norm = mag << lz; top bit at 63.
  logic [95:0] frame_d;
  logic [5:0]  p_d;
  always_comb begin
    frame_d = {32'd0, mag_q1} << sh_q1;
    p_d     = 6'(7'd63 - sh_q1);
  end

  logic        f2i_q2, uns_q2, neg_q2, ill_q2, spec_q2, zero_q2;
  logic [2:0]  mode_q2;
  logic [95:0] frame_q2;
  logic [63:0] specr_q2;
  logic [5:0]  p_q2;
  always_ff @(posedge clk_i) begin
    if (en2) begin
      f2i_q2 <= f2i_q1; uns_q2 <= uns_q1; neg_q2 <= neg_q1; ill_q2 <= ill_q1;
      spec_q2 <= spec_q1; zero_q2 <= zero_q1; mode_q2 <= mode_q1;
      frame_q2 <= frame_d; specr_q2 <= specr_q1; p_q2 <= p_d;
    end
  end

  // ---------------- stage 3: round ----------------
  logic [64:0] rmag_d;
  logic        inx_d;
  logic        lsb, grd, stk;
  always_comb begin
    if (f2i_q2) begin
      lsb = frame_q2[32];
      grd = frame_q2[31];
      stk = |frame_q2[30:0];
      rmag_d = {1'b0, frame_q2[95:32]} +
               65'(round_up(mode_q2, neg_q2, lsb, grd, stk));
    end else begin
      // norm in frame_q2[63:0]; mantissa [63:40]
      lsb = frame_q2[40];
      grd = frame_q2[39];
      stk = |frame_q2[38:0];
      rmag_d = {41'd0, frame_q2[63:40]} +
               65'(round_up(mode_q2, neg_q2, lsb, grd, stk));
    end
    inx_d = grd | stk;
  end

  logic        f2i_q3, uns_q3, neg_q3, ill_q3, spec_q3, zero_q3, inx_q3;
  logic [64:0] rmag_q3;
  logic [63:0] specr_q3;
  logic [5:0]  p_q3;
  always_ff @(posedge clk_i) begin
    if (en3) begin
      f2i_q3 <= f2i_q2; uns_q3 <= uns_q2; neg_q3 <= neg_q2; ill_q3 <= ill_q2;
      spec_q3 <= spec_q2; zero_q3 <= zero_q2; inx_q3 <= inx_d;
      rmag_q3 <= rmag_d; specr_q3 <= specr_q2; p_q3 <= p_q2;
    end
  end

  // ---------------- stage 4: saturate, pack ----------------
  logic [63:0] res_d;
  logic [4:0]  flg_d;
  logic [23:0] q;
  logic [7:0]  bexp;
  always_comb begin
    res_d = '0;
    flg_d = '0;
    q     = '0;
    bexp  = '0;
    if (ill_q3) begin
      res_d = '0;
    end else if (spec_q3) begin
      res_d = specr_q3;
      flg_d = FLAG_NV;
    end else if (f2i_q3) begin
      if (uns_q3) begin
        if (neg_q3 && rmag_q3 != 65'd0) begin
          res_d = '0; flg_d = FLAG_NV;
        end else begin
          res_d = rmag_q3[63:0]; flg_d = inx_q3 ? FLAG_NX : 5'd0;
        end
      end else if (neg_q3) begin
        if (rmag_q3 > 65'h0_8000_0000_0000_0000) begin
          res_d = 64'h8000_0000_0000_0000; flg_d = FLAG_NV;
        end else begin
          res_d = 64'd0 - rmag_q3[63:0]; flg_d = inx_q3 ? FLAG_NX : 5'd0;
        end
      end else begin
        if (rmag_q3 > 65'h0_7FFF_FFFF_FFFF_FFFF) begin
          res_d = 64'h7FFF_FFFF_FFFF_FFFF; flg_d = FLAG_NV;
        end else begin
          res_d = rmag_q3[63:0]; flg_d = inx_q3 ? FLAG_NX : 5'd0;
        end
      end
    end else if (zero_q3) begin
      res_d = {BOX_HIGH, 32'd0};
    end else begin
      // mantissa carry out renormalizes
      if (rmag_q3[24]) begin
        q    = rmag_q3[24:1];
        bexp = 8'(p_q3) + 8'd128;
      end else begin
        q    = rmag_q3[23:0];
        bexp = 8'(p_q3) + 8'd127;
      end
      res_d = {BOX_HIGH, neg_q3, bexp, q[22:0]};
      flg_d = inx_q3 ? FLAG_NX : 5'd0;
    end
  end

  logic [63:0] res_q4;
  logic [4:0]  flg_q4;
  logic        ill_q4;
  always_ff @(posedge clk_i) begin
    if (en4) begin
      res_q4 <= res_d; flg_q4 <= flg_d; ill_q4 <= ill_q3;
    end
  end

  assign out_valid_o        = v4_q;
  assign result_bits_o      = res_q4;
  assign exception_flags_o  = flg_q4;
  assign illegal_rounding_o = ill_q4;

endmodule
